// ===== sv/console_line_editor_macros.svh =====
// Assertion macros for the console line editor.
// Included by the modules that check their own logic; needs a clk and rst in scope.
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CLE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console_line_editor check failed");

// Next-cycle implication, checked outside reset.
`define CLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console_line_editor check failed");

`endif

// ===== sv/cle_pkg.sv =====
// Shared types and constants for the console line editor.
// Used by cle_ctrl, cle_datapath and console_line_editor; no dependencies.
package cle_pkg;

  localparam int LINE_CAP = 32;
  localparam int FILL_W   = $clog2(LINE_CAP + 1);
  localparam int ADDR_W   = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
  localparam int LEN_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;

  localparam logic [LEN_W-1:0] MAX_LINE_LEN_RESET = 6'd32;

  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_BS     = 8'd8;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'd10;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'd13;
  localparam logic [BYTE_W-1:0] CH_ESC    = 8'd27;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'd32;
  localparam logic [BYTE_W-1:0] CH_AT     = 8'd64;
  localparam logic [BYTE_W-1:0] CH_O      = 8'd79;
  localparam logic [BYTE_W-1:0] CH_LBRACK = 8'd91;
  localparam logic [BYTE_W-1:0] CH_TILDE  = 8'd126;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'd127;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_BS,
    SRC_SP,
    SRC_CR,
    SRC_LF,
    SRC_RX,
    SRC_MEM
  } src_t;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_ESC,
    CLS_ERASE,
    CLS_CR,
    CLS_PRINT
  } cls_t;

  typedef struct packed {
    logic              rx_load;
    logic              load;
    logic [KIND_W-1:0] kind;
    src_t              src;
    logic              len_sel;
    logic              last;
    logic              store_wr;
    logic              fill_inc;
    logic              fill_dec;
    logic              fill_clr;
    logic              rd_clr;
    logic              rd_inc;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic is_intro;
    logic is_final;
    logic fill_zero;
    logic room;
    logic rd_more;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/cle_ctrl.sv =====
// Controller of the console line editor: escape tracking and result sequencing.
// Depends on cle_pkg; drives cle_datapath through cmd_t, reads sts_t.
module cle_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cle_pkg::sts_t sts,
  output cle_pkg::cmd_t cmd
);
  import cle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SP,
    S_BS2,
    S_LF,
    S_LREAD,
    S_LOUT,
    S_END
  } state_t;

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_INTRO,
    ESC_BODY
  } esc_t;

  state_t state, state_next;
  esc_t   esc, esc_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    esc_next   = esc;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.rx_load = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
          if (esc == ESC_INTRO) begin
            esc_next = sts.is_intro ? ESC_BODY : ESC_NONE;
          end else if (esc == ESC_BODY) begin
            if (sts.is_final) esc_next = ESC_NONE;
          end else begin
            case (sts.cls)
              CLS_ESC: esc_next = ESC_INTRO;
              CLS_ERASE: begin
                if (!sts.fill_zero) begin
                  cmd.fill_dec = 1'b1;
                  cmd.load     = 1'b1;
                  cmd.kind     = KIND_ECHO;
                  cmd.src      = SRC_BS;
                  state_next   = S_SP;
                end
              end
              CLS_CR: begin
                cmd.load   = 1'b1;
                cmd.kind   = KIND_ECHO;
                cmd.src    = SRC_CR;
                cmd.rd_clr = 1'b1;
                state_next = S_LF;
              end
              CLS_PRINT: begin
                if (sts.room) begin
                  cmd.store_wr = 1'b1;
                  cmd.fill_inc = 1'b1;
                  cmd.load     = 1'b1;
                  cmd.kind     = KIND_ECHO;
                  cmd.src      = SRC_RX;
                  cmd.last     = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      S_SP: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_ECHO;
          cmd.src    = SRC_SP;
          state_next = S_BS2;
        end
      end
      S_BS2: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_ECHO;
          cmd.src    = SRC_BS;
          cmd.last   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LF: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_ECHO;
          cmd.src    = SRC_LF;
          state_next = sts.fill_zero ? S_END : S_LREAD;
        end
      end
      S_LREAD: state_next = S_LOUT;
      S_LOUT: begin
        if (sts.out_free) begin
          cmd.load   = 1'b1;
          cmd.kind   = KIND_LINE;
          cmd.src    = SRC_MEM;
          cmd.rd_inc = 1'b1;
          state_next = sts.rd_more ? S_LREAD : S_END;
        end
      end
      S_END: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.kind     = KIND_END;
          cmd.src      = SRC_ZERO;
          cmd.len_sel  = 1'b1;
          cmd.last     = 1'b1;
          cmd.fill_clr = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      esc   <= ESC_NONE;
    end else begin
      state <= state_next;
      esc   <= esc_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== sv/cle_datapath.sv =====
// Datapath of the console line editor: received byte, line store, fill count,
// read pointer and output register. Depends on cle_pkg and the macro header.
`include "console_line_editor_macros.svh"

module cle_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cle_pkg::BYTE_W-1:0]   rx_byte,
  input  logic [cle_pkg::LEN_W-1:0]    max_line_len,
  input  cle_pkg::cmd_t                cmd,
  output cle_pkg::sts_t                sts,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cle_pkg::KIND_W-1:0]   out_kind,
  output logic [cle_pkg::BYTE_W-1:0]   out_byte,
  output logic [cle_pkg::LEN_W-1:0]    line_length,
  output logic                         last
);
  import cle_pkg::*;

  localparam int CNT_W = FILL_W + 1;

  logic [BYTE_W-1:0] rx;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] rd_idx;
  logic [BYTE_W-1:0] rd_data;
  logic [BYTE_W-1:0] mem [LINE_CAP];
  logic [BYTE_W-1:0] src_byte;
  cls_t              cls;

  always_comb begin
    case (rx) inside
      CH_ESC:             cls = CLS_ESC;
      CH_DEL, CH_BS:      cls = CLS_ERASE;
      CH_CR:              cls = CLS_CR;
      [CH_SPACE:CH_TILDE]: cls = CLS_PRINT;
      default:            cls = CLS_OTHER;
    endcase
  end

  always_comb begin
    sts.cls       = cls;
    sts.is_intro  = (rx == CH_LBRACK) || (rx == CH_O);
    sts.is_final  = rx inside {[CH_AT:CH_TILDE]};
    sts.fill_zero = (fill == '0);
    sts.room      = (LEN_W'(fill) < max_line_len) && (fill < FILL_W'(LINE_CAP));
    sts.rd_more   = (CNT_W'(rd_idx) + CNT_W'(1)) < CNT_W'(fill);
    sts.out_free  = !out_valid || !out_stall;
  end

  always_comb begin
    case (cmd.src)
      SRC_BS:  src_byte = CH_BS;
      SRC_SP:  src_byte = CH_SPACE;
      SRC_CR:  src_byte = CH_CR;
      SRC_LF:  src_byte = CH_LF;
      SRC_RX:  src_byte = rx;
      SRC_MEM: src_byte = rd_data;
      default: src_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) mem[fill[ADDR_W-1:0]] <= rx;
    rd_data <= mem[rd_idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_load) rx <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      rd_idx <= '0;
    end else begin
      if (cmd.fill_clr)      fill <= '0;
      else if (cmd.fill_inc) fill <= fill + FILL_W'(1);
      else if (cmd.fill_dec) fill <= fill - FILL_W'(1);
      if (cmd.rd_clr)        rd_idx <= '0;
      else if (cmd.rd_inc)   rd_idx <= rd_idx + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_kind    <= cmd.kind;
      out_byte    <= src_byte;
      line_length <= cmd.len_sel ? LEN_W'(fill) : '0;
      last        <= cmd.last;
    end
  end

  `CLE_ASSERT_NOW(a_fill_cap, 1'b1, fill <= FILL_W'(LINE_CAP))
  `CLE_ASSERT_NOW(a_store_room, cmd.store_wr, sts.room)
  `CLE_ASSERT_NOW(a_erase_nonempty, cmd.fill_dec, !sts.fill_zero)
  `CLE_ASSERT_NOW(a_load_free, cmd.load, sts.out_free)
  `CLE_ASSERT_NOW(a_read_in_line, cmd.rd_inc, rd_idx < fill)

endmodule

// ===== sv/console_line_editor.sv =====
// A taken byte is registered, then decoded; its first result enters the output
// register once that is free. A new byte is taken only after all results of the
// last one (each line byte is one registered read of the line store).
// Reset: synchronous, clears line length, escape state, output and limit (32);
// line store contents are not cleared.
// Top level: APB limit register, cle_ctrl and cle_datapath. Depends on cle_pkg.
module console_line_editor (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [cle_pkg::BYTE_W-1:0]   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cle_pkg::KIND_W-1:0]   out_kind,
  output logic [cle_pkg::BYTE_W-1:0]   out_byte,
  output logic [cle_pkg::LEN_W-1:0]    line_length,
  output logic                         last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import cle_pkg::*;

  logic [LEN_W-1:0] max_line_len;
  cmd_t             cmd;
  sts_t             sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(max_line_len) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len <= MAX_LINE_LEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      max_line_len <= pwdata[LEN_W-1:0];
    end
  end

  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cle_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .rx_byte      (rx_byte),
    .max_line_len (max_line_len),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .line_length  (line_length),
    .last         (last)
  );

endmodule

// ===== tb/sv/tb_console_line_editor.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for console_line_editor: echo, erase, escape skip and line dump.
// Needs cle_pkg and the console_line_editor RTL; predicts every result item in-line.

module tb_console_line_editor;
  import cle_pkg::*;

  localparam logic [2:0] REG_MAX_LINE_LEN = 3'd0;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS = 8;
  localparam int NUM_PHASES = 6;

  localparam logic [BYTE_W-1:0] DIRECTED_BYTES [25] = '{
    CH_SPACE, CH_TILDE, 8'd65, CH_CR,
    CH_CR,
    CH_BS, CH_DEL,
    8'd120, CH_DEL,
    CH_ESC, CH_LBRACK, CH_CR, CH_DEL, CH_ESC, CH_TILDE,
    CH_ESC, CH_O, 8'd80,
    CH_ESC, 8'd122,
    8'd113, 8'd0, 8'd255, 8'd128, CH_CR
  };

  localparam int PHASE_LIMIT [NUM_PHASES] = '{63, 3, 32, 0, 1, 20};
  localparam int PHASE_SEND_IDLE [NUM_PHASES] = '{0, 76, 0, 22, 0, 22};
  localparam int PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 76, 22, 0, 22};

  typedef enum logic [1:0] {
    ESC_NONE,
    ESC_INTRO,
    ESC_BODY
  } esc_state_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  length;
    logic              last;
  } editor_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BYTE_W-1:0]  rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KIND_W-1:0]  out_kind;
  logic [BYTE_W-1:0]  out_byte;
  logic [LEN_W-1:0]   line_length;
  logic               last;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  logic [BYTE_W-1:0]  rx_pending [$];
  editor_out_t        editor_out_q [$];

  esc_state_t         esc_state = ESC_NONE;
  int                 fill = 0;
  logic [BYTE_W-1:0]  line_buf [LINE_CAP];
  logic [LEN_W-1:0]   limit_reg = MAX_LINE_LEN_RESET;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;

  console_line_editor dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_kind(out_kind),
    .out_byte(out_byte),
    .line_length(line_length),
    .last(last),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  function automatic editor_out_t make_out(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                           logic [LEN_W-1:0] length);
    editor_out_t r;
    r.kind = kind;
    r.data = data;
    r.length = length;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic edit_line(input logic [BYTE_W-1:0] c);
    int eff_limit;
    int prior;
    editor_out_t tail;
    eff_limit = (int'(limit_reg) < LINE_CAP) ? int'(limit_reg) : LINE_CAP;
    prior = editor_out_q.size();
    case (esc_state)
      ESC_INTRO: begin
        esc_state = (c == CH_LBRACK || c == CH_O) ? ESC_BODY : ESC_NONE;
      end
      ESC_BODY: begin
        if (c >= CH_AT && c <= CH_TILDE) esc_state = ESC_NONE;
      end
      default: begin
        if (c == CH_ESC) begin
          esc_state = ESC_INTRO;
        end else if (c == CH_DEL || c == CH_BS) begin
          if (fill > 0) begin
            fill--;
            editor_out_q.push_back(make_out(KIND_ECHO, CH_BS, '0));
            editor_out_q.push_back(make_out(KIND_ECHO, CH_SPACE, '0));
            editor_out_q.push_back(make_out(KIND_ECHO, CH_BS, '0));
          end
        end else if (c == CH_CR) begin
          editor_out_q.push_back(make_out(KIND_ECHO, CH_CR, '0));
          editor_out_q.push_back(make_out(KIND_ECHO, CH_LF, '0));
          for (int i = 0; i < fill; i++)
            editor_out_q.push_back(make_out(KIND_LINE, line_buf[i], '0));
          editor_out_q.push_back(make_out(KIND_END, '0, LEN_W'(fill)));
          fill = 0;
        end else if (c >= CH_SPACE && c <= CH_TILDE && fill < eff_limit) begin
          line_buf[fill] = c;
          fill++;
          editor_out_q.push_back(make_out(KIND_ECHO, c, '0));
        end
      end
    endcase
    if (editor_out_q.size() > prior) begin
      tail = editor_out_q.pop_back();
      tail.last = 1'b1;
      editor_out_q.push_back(tail);
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic queue_random_burst(input int eff_limit);
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      n = $urandom_range(1, 8);
      repeat (n) rx_pending.push_back(BYTE_W'($urandom_range(32, 126)));
    end else if (pick < 50) begin
      n = $urandom_range(1, 3);
      repeat (n) rx_pending.push_back($urandom_range(0, 1) ? CH_BS : CH_DEL);
    end else if (pick < 62) begin
      rx_pending.push_back(CH_CR);
    end else if (pick < 74) begin
      rx_pending.push_back(CH_ESC);
      rx_pending.push_back($urandom_range(0, 1) ? CH_LBRACK : CH_O);
      n = $urandom_range(0, 3);
      repeat (n)
        rx_pending.push_back($urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 63))
                                                  : BYTE_W'($urandom_range(127, 255)));
      rx_pending.push_back(BYTE_W'($urandom_range(64, 126)));
    end else if (pick < 78) begin
      rx_pending.push_back(CH_ESC);
      rx_pending.push_back(BYTE_W'($urandom));
    end else if (pick < 93) begin
      rx_pending.push_back(BYTE_W'($urandom));
    end else begin
      n = $urandom_range(eff_limit, eff_limit + 3);
      repeat (n) rx_pending.push_back(BYTE_W'($urandom_range(32, 126)));
      rx_pending.push_back(CH_CR);
    end
  endtask

  task automatic wait_drained;
    do @(posedge clk);
    while (rx_pending.size() != 0 || in_valid || editor_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : sender
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) edit_line(rx_byte);
      if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        rx_byte <= rx_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receiver
    editor_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (editor_out_q.size() == 0) begin
          $display("%0t: unexpected item kind=%0d byte=%0d length=%0d last=%0d",
                   $time, out_kind, out_byte, line_length, last);
          errors++;
        end else begin
          want = editor_out_q.pop_front();
          check_field("out_kind", want.kind, out_kind);
          check_field("out_byte", want.data, out_byte);
          check_field("line_length", want.length, line_length);
          check_field("last", want.last, last);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int eff_limit;
    int target;
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED_BYTES[i]) rx_pending.push_back(DIRECTED_BYTES[i]);
    wait_drained();
    for (int p = 0; p < NUM_PHASES; p++) begin
      @(posedge clk);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= REG_MAX_LINE_LEN;
      pwdata <= 32'(PHASE_LIMIT[p]);
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk);
      while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      limit_reg = LEN_W'(PHASE_LIMIT[p]);
      send_idle_pct = PHASE_SEND_IDLE[p];
      recv_stall_pct = PHASE_RECV_STALL[p];
      eff_limit = (PHASE_LIMIT[p] < LINE_CAP) ? PHASE_LIMIT[p] : LINE_CAP;
      target = PHASE_ITEMS;
      while (rx_pending.size() < target) queue_random_burst(eff_limit);
      // leave a partial line behind so the next limit change meets stored characters
      n = $urandom_range(2, 4);
      repeat (n) rx_pending.push_back(BYTE_W'($urandom_range(32, 126)));
      wait_drained();
    end
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
